// ===== rtl/fbat_pkg.sv =====
// Shared types and constants of the file block allocation table.
package fbat_pkg;

    localparam int NUM_BLOCKS      = 128;
    localparam int NUM_ENTRIES     = 16;
    localparam int MAX_FILE_BLOCKS = 8;

    localparam int BLK_W   = 7;
    localparam int ENT_W   = 4;
    localparam int CNT_W   = 4;
    localparam int IDX_W   = 3;
    localparam int NAME_W  = 64;
    localparam int PTR_W   = $clog2(MAX_FILE_BLOCKS);
    localparam int PADDR_W = ENT_W + PTR_W;
    localparam int PTR_DEPTH = NUM_ENTRIES * MAX_FILE_BLOCKS;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_MAP    = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_NO_ENTRY  = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [NAME_W-1:0] name_word;
        logic [CNT_W-1:0]  block_count;
        logic [IDX_W-1:0]  block_index;
    } cmd_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [BLK_W-1:0] disk_block;
        logic [ENT_W-1:0] entry_index;
        logic [CNT_W-1:0] file_blocks;
    } result_t;

    // Entry table write control.
    typedef struct packed {
        logic              set;
        logic              clr;
        logic [ENT_W-1:0]  idx;
        logic [NAME_W-1:0] name;
        logic [CNT_W-1:0]  size;
    } ent_wr_t;

    // Entry table view of the entry under the scan index.
    typedef struct packed {
        logic             valid;
        logic             name_eq;
        logic [CNT_W-1:0] size;
    } ent_view_t;

endpackage

// ===== rtl/fbat_ptr_ram.sv =====
// Block pointer memory: one write port, one registered read port.
module fbat_ptr_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 7
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/fbat_entry_table.sv =====
// File entry table: valid bits, names, sizes and the shared name comparator.
module fbat_entry_table (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fbat_pkg::ent_wr_t       wr,
    input  logic [fbat_pkg::ENT_W-1:0]  rd_idx,
    input  logic [fbat_pkg::NAME_W-1:0] cmp_name,
    output fbat_pkg::ent_view_t     view
);

    import fbat_pkg::*;

    logic [NUM_ENTRIES-1:0] valid_reg;
    logic [NAME_W-1:0]      name_reg [NUM_ENTRIES];
    logic [CNT_W-1:0]       size_reg [NUM_ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.set)
        begin
            valid_reg[wr.idx] <= 1'b1;
        end
        else if (wr.clr)
        begin
            valid_reg[wr.idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.set)
        begin
            name_reg[wr.idx] <= wr.name;
            size_reg[wr.idx] <= wr.size;
        end
    end

    // Compare the scanned entry against the command name.
    assign view.valid   = valid_reg[rd_idx];
    assign view.name_eq = (name_reg[rd_idx] == cmp_name);
    assign view.size    = size_reg[rd_idx];

endmodule

// ===== rtl/file_block_allocation_table.sv =====
// Top level of the file block allocation table: sequencer, bitmap and result register.
//
// Usage: drive cmd and raise start; the command is taken at a rising edge where
// start is high and busy is low. busy stays high while the sequencer walks the
// entry table and the free-block bitmap. The single result of each transaction
// appears on result, marked by done for exactly one cycle; the receiver cannot
// hold it off, so capture it in that cycle.
//
// Sequence (one entry or one bitmap bit per cycle; a delete pauses its entry scan
// while it releases the blocks of a match):
//   create   : entry scan, free count, check, allocate
//   delete   : entry scan plus, for each matching entry, a pointer memory read and
//              a bitmap clear per released block
//   map      : entry scan, then a pointer memory read when an entry matches
//   too large or unknown operation: result in the cycle after the command is taken
// The bitmap scans dominate create; the registered pointer read sets delete's cost.
//
// Reset clears the bitmap (every block free) and every entry valid bit at once;
// a command can be taken in the first cycle after reset.
module file_block_allocation_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  fbat_pkg::cmd_t     cmd,
    output logic               busy,
    output logic               done,
    output fbat_pkg::result_t  result
);

    import fbat_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_C_ENT,
        S_C_SCAN,
        S_C_CHK,
        S_C_ALLOC,
        S_D_ENT,
        S_D_RD,
        S_D_CLR,
        S_M_ENT,
        S_M_RD,
        S_M_WAIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [NAME_W-1:0]      name_reg, name_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       bidx_reg, bidx_next;
    logic [ENT_W-1:0]       ent_reg, ent_next;
    logic [BLK_W-1:0]       blk_reg, blk_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   hit_reg, hit_next;
    logic [ENT_W-1:0]       sel_ent_reg, sel_ent_next;
    logic [CNT_W-1:0]       sel_size_reg, sel_size_next;
    logic [BLK_W-1:0]       first_reg, first_next;
    logic                   done_reg, done_next;
    result_t                res_reg, res_next;
    logic [NUM_BLOCKS-1:0]  used_reg, used_next;

    ent_wr_t                ent_wr;
    ent_view_t              view;
    logic                   ram_we;
    logic [PADDR_W-1:0]     ram_waddr;
    logic [PADDR_W-1:0]     ram_raddr;
    logic [BLK_W-1:0]       ram_rdata;
    logic                   ent_last;
    logic                   blk_last;
    logic                   blk_free;

    function automatic result_t make_result(status_t st, logic [BLK_W-1:0] blk,
                                            logic [ENT_W-1:0] ent,
                                            logic [CNT_W-1:0] sz);
        result_t r;
        r.status      = st;
        r.disk_block  = blk;
        r.entry_index = ent;
        r.file_blocks = sz;
        return r;
    endfunction

    fbat_entry_table u_entries (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (ent_wr),
        .rd_idx   (ent_reg),
        .cmp_name (name_reg),
        .view     (view)
    );

    fbat_ptr_ram #(
        .DEPTH (PTR_DEPTH),
        .WIDTH (BLK_W)
    ) u_ptr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (blk_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent_last  = (ent_reg == ENT_W'(NUM_ENTRIES - 1));
    assign blk_last  = (blk_reg == BLK_W'(NUM_BLOCKS - 1));
    assign blk_free  = !used_reg[blk_reg];
    assign ram_waddr = {sel_ent_reg, cnt_reg[PTR_W-1:0]};

    always_comb
    begin
        state_next    = state_reg;
        name_next     = name_reg;
        count_next    = count_reg;
        bidx_next     = bidx_reg;
        ent_next      = ent_reg;
        blk_next      = blk_reg;
        cnt_next      = cnt_reg;
        hit_next      = hit_reg;
        sel_ent_next  = sel_ent_reg;
        sel_size_next = sel_size_reg;
        first_next    = first_reg;
        done_next     = 1'b0;
        res_next      = res_reg;
        used_next     = used_reg;

        ent_wr.set    = 1'b0;
        ent_wr.clr    = 1'b0;
        ent_wr.idx    = ent_reg;
        ent_wr.name   = name_reg;
        ent_wr.size   = count_reg;
        ram_we        = 1'b0;
        ram_raddr     = {ent_reg, cnt_reg[PTR_W-1:0]};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    name_next  = cmd.name_word;
                    count_next = cmd.block_count;
                    bidx_next  = cmd.block_index;
                    ent_next   = '0;
                    blk_next   = '0;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    first_next = '0;
                    case (cmd.operation)
                        OP_CREATE:
                        begin
                            if (cmd.block_count > CNT_W'(MAX_FILE_BLOCKS))
                            begin
                                done_next = 1'b1;
                                res_next  = make_result(ST_TOO_LARGE, '0, '0, '0);
                            end
                            else
                            begin
                                state_next = S_C_ENT;
                            end
                        end
                        OP_DELETE: state_next = S_D_ENT;
                        OP_MAP:    state_next = S_M_ENT;
                        default:
                        begin
                            done_next = 1'b1;
                            res_next  = make_result(ST_NOT_FOUND, '0, '0, '0);
                        end
                    endcase
                end
            end

            // Find the first free entry.
            S_C_ENT:
            begin
                if (!view.valid)
                begin
                    hit_next     = 1'b1;
                    sel_ent_next = ent_reg;
                    state_next   = S_C_SCAN;
                end
                else if (ent_last)
                begin
                    state_next = S_C_SCAN;
                end
                else
                begin
                    ent_next = ent_reg + 1'b1;
                end
            end

            // Count free blocks until the request is covered; remember the first.
            S_C_SCAN:
            begin
                if (cnt_reg == count_reg)
                begin
                    state_next = S_C_CHK;
                end
                else
                begin
                    if (blk_free)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg == '0)
                        begin
                            first_next = blk_reg;
                        end
                    end
                    if (blk_last)
                    begin
                        state_next = S_C_CHK;
                    end
                    else
                    begin
                        blk_next = blk_reg + 1'b1;
                    end
                end
            end

            S_C_CHK:
            begin
                if (cnt_reg != count_reg)
                begin
                    done_next  = 1'b1;
                    res_next   = make_result(ST_NO_SPACE, '0, '0, '0);
                    state_next = S_IDLE;
                end
                else if (!hit_reg)
                begin
                    done_next  = 1'b1;
                    res_next   = make_result(ST_NO_ENTRY, '0, '0, '0);
                    state_next = S_IDLE;
                end
                else
                begin
                    blk_next   = '0;
                    cnt_next   = '0;
                    state_next = S_C_ALLOC;
                end
            end

            // Mark free blocks in ascending order and record them as pointers.
            S_C_ALLOC:
            begin
                if (cnt_reg == count_reg)
                begin
                    ent_wr.set = 1'b1;
                    ent_wr.idx = sel_ent_reg;
                    done_next  = 1'b1;
                    res_next   = make_result(ST_OK, first_reg, sel_ent_reg, count_reg);
                    state_next = S_IDLE;
                end
                else
                begin
                    if (blk_free)
                    begin
                        used_next[blk_reg] = 1'b1;
                        ram_we             = 1'b1;
                        cnt_next           = cnt_reg + 1'b1;
                    end
                    blk_next = blk_reg + 1'b1;
                end
            end

            // Drop every matching entry; the last match is reported.
            S_D_ENT:
            begin
                if (view.valid && view.name_eq)
                begin
                    hit_next      = 1'b1;
                    sel_ent_next  = ent_reg;
                    sel_size_next = view.size;
                    cnt_next      = '0;
                    ent_wr.clr    = 1'b1;
                    state_next    = S_D_RD;
                end
                else if (ent_last)
                begin
                    done_next  = 1'b1;
                    res_next   = hit_reg
                               ? make_result(ST_OK, '0, sel_ent_reg, sel_size_reg)
                               : make_result(ST_NOT_FOUND, '0, '0, '0);
                    state_next = S_IDLE;
                end
                else
                begin
                    ent_next = ent_reg + 1'b1;
                end
            end

            S_D_RD:
            begin
                if (cnt_reg == sel_size_reg)
                begin
                    if (ent_last)
                    begin
                        done_next  = 1'b1;
                        res_next   = make_result(ST_OK, '0, sel_ent_reg, sel_size_reg);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ent_next   = ent_reg + 1'b1;
                        state_next = S_D_ENT;
                    end
                end
                else
                begin
                    state_next = S_D_CLR;
                end
            end

            // Release the block read from the pointer memory.
            S_D_CLR:
            begin
                used_next[ram_rdata] = 1'b0;
                cnt_next             = cnt_reg + 1'b1;
                state_next           = S_D_RD;
            end

            // Last valid entry with matching name and enough blocks wins.
            S_M_ENT:
            begin
                if (view.valid && view.name_eq && (CNT_W'(bidx_reg) < view.size))
                begin
                    hit_next      = 1'b1;
                    sel_ent_next  = ent_reg;
                    sel_size_next = view.size;
                end
                if (ent_last)
                begin
                    state_next = S_M_RD;
                end
                else
                begin
                    ent_next = ent_reg + 1'b1;
                end
            end

            S_M_RD:
            begin
                ram_raddr = {sel_ent_reg, bidx_reg[PTR_W-1:0]};
                if (hit_reg)
                begin
                    state_next = S_M_WAIT;
                end
                else
                begin
                    done_next  = 1'b1;
                    res_next   = make_result(ST_NOT_FOUND, '0, '0, '0);
                    state_next = S_IDLE;
                end
            end

            S_M_WAIT:
            begin
                done_next  = 1'b1;
                res_next   = make_result(ST_OK, ram_rdata, sel_ent_reg, sel_size_reg);
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            used_reg  <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            used_reg  <= used_next;
            hit_reg   <= hit_next;
        end
    end

    // Payload and scan registers need no reset.
    always_ff @(posedge clk)
    begin
        name_reg     <= name_next;
        count_reg    <= count_next;
        bidx_reg     <= bidx_next;
        ent_reg      <= ent_next;
        blk_reg      <= blk_next;
        cnt_reg      <= cnt_next;
        sel_ent_reg  <= sel_ent_next;
        sel_size_reg <= sel_size_next;
        first_reg    <= first_next;
        res_reg      <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // A successful result only comes out of a sequenced command.
    a_ok_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_OK) |-> $past(busy))
        else $error("ok result without a sequenced command");

    // Failure results carry no block, entry or size.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status != ST_OK) |->
            (result.disk_block == '0) && (result.entry_index == '0) &&
            (result.file_blocks == '0))
        else $error("failure result with nonzero fields");

    // No file ever exceeds the per-file block limit.
    a_size_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_OK) |->
            (result.file_blocks <= CNT_W'(MAX_FILE_BLOCKS)))
        else $error("file size above limit");

endmodule

// ===== tb/file_block_allocation_table_tb.sv =====
// Self-checking testbench for the file block allocation table: directed cases, then random traffic.
module file_block_allocation_table_tb;

    import fbat_pkg::*;

    // Operation code 3 has no member in op_t; the block must answer it with not found.
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    // Allow the worst create plus slack after the last result.
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int PHASE_ITEMS   = 40;
    localparam int POOL_SIZE     = 8;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd = '0;
    logic    busy;
    logic    done;
    result_t result;

    file_block_allocation_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    // Mirror of the block's metadata: bitmap, entry table and block pointers.
    logic              blocks_taken [NUM_BLOCKS];
    logic              slot_live    [NUM_ENTRIES];
    logic [NAME_W-1:0] slot_name    [NUM_ENTRIES];
    logic [CNT_W-1:0]  slot_size    [NUM_ENTRIES];
    logic [BLK_W-1:0]  slot_map     [NUM_ENTRIES][MAX_FILE_BLOCKS];

    // Responses predicted for accepted transactions, oldest first.
    result_t           pending_responses [$];
    int                error_count = 0;

    // Small name pool so that deletes and maps hit existing files often.
    logic [NAME_W-1:0] name_pool [POOL_SIZE];
    bit                gaps_on = 1'b1;

    // Apply one command to the mirrored metadata and return the response it causes.
    function automatic result_t apply_command(input cmd_t c);
        result_t r;
        int      picks [MAX_FILE_BLOCKS];
        int      found;
        int      ent;
        int      last;
        int      last_size;
        bit      hit;
        r = '0;
        found = 0;
        ent = -1;
        last = 0;
        last_size = 0;
        hit = 1'b0;
        case (c.operation)
            OP_CREATE:
            begin
                if (c.block_count > MAX_FILE_BLOCKS)
                begin
                    r.status = ST_TOO_LARGE;
                end
                else
                begin
                    // Take the lowest free blocks in ascending order.
                    for (int i = 0; i < NUM_BLOCKS && found < c.block_count; i++)
                    begin
                        if (!blocks_taken[i])
                        begin
                            picks[found] = i;
                            found++;
                        end
                    end
                    // No space takes priority over no free entry.
                    for (int i = NUM_ENTRIES - 1; i >= 0; i--)
                    begin
                        if (!slot_live[i])
                            ent = i;
                    end
                    if (found < c.block_count)
                    begin
                        r.status = ST_NO_SPACE;
                    end
                    else if (ent < 0)
                    begin
                        r.status = ST_NO_ENTRY;
                    end
                    else
                    begin
                        slot_live[ent] = 1'b1;
                        slot_name[ent] = c.name_word;
                        slot_size[ent] = c.block_count;
                        for (int i = 0; i < c.block_count; i++)
                        begin
                            blocks_taken[picks[i]] = 1'b1;
                            slot_map[ent][i] = BLK_W'(picks[i]);
                        end
                        r.status      = ST_OK;
                        r.disk_block  = (found > 0) ? BLK_W'(picks[0]) : '0;
                        r.entry_index = ENT_W'(ent);
                        r.file_blocks = c.block_count;
                    end
                end
            end
            OP_DELETE:
            begin
                // Every matching entry goes; the highest one is reported.
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    if (slot_live[i] && slot_name[i] == c.name_word)
                    begin
                        hit = 1'b1;
                        last = i;
                        last_size = slot_size[i];
                        for (int j = 0; j < slot_size[i]; j++)
                            blocks_taken[slot_map[i][j]] = 1'b0;
                        for (int j = 0; j < MAX_FILE_BLOCKS; j++)
                            slot_map[i][j] = '0;
                        slot_live[i] = 1'b0;
                        slot_name[i] = '0;
                        slot_size[i] = '0;
                    end
                end
                if (hit)
                begin
                    r.status      = ST_OK;
                    r.entry_index = ENT_W'(last);
                    r.file_blocks = CNT_W'(last_size);
                end
                else
                begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_MAP:
            begin
                // The last valid entry with a matching name and enough blocks wins.
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    if (slot_live[i] && slot_name[i] == c.name_word &&
                        c.block_index < slot_size[i])
                    begin
                        hit = 1'b1;
                        r.disk_block  = slot_map[i][c.block_index];
                        r.entry_index = ENT_W'(i);
                        r.file_blocks = slot_size[i];
                    end
                end
                if (hit)
                    r.status = ST_OK;
                else
                    r = '{status: ST_NOT_FOUND, default: '0};
            end
            default:
            begin
                r.status = ST_NOT_FOUND;
            end
        endcase
        return r;
    endfunction

    function automatic cmd_t make_cmd(input logic [1:0] op, input logic [NAME_W-1:0] nm,
                                      input int cnt, input int idx);
        cmd_t c;
        c.operation   = op;
        c.name_word   = nm;
        c.block_count = CNT_W'(cnt);
        c.block_index = IDX_W'(idx);
        return c;
    endfunction

    function automatic logic [NAME_W-1:0] pick_name();
        // Mostly pool names, sometimes a fresh random name as noise.
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        return name_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Gap before the next transaction: mostly none or short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Pick the name of a live file most of the time, with its size for map indexes.
    task automatic choose_target(output logic [NAME_W-1:0] nm, output int sz);
        int live [$];
        int k;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (slot_live[i])
                live = {live, i};
        end
        if (live.size() > 0 && $urandom_range(0, 3) != 0)
        begin
            k  = live[$urandom_range(0, live.size() - 1)];
            nm = slot_name[k];
            sz = slot_size[k];
        end
        else
        begin
            nm = pick_name();
            sz = MAX_FILE_BLOCKS;
        end
    endtask

    // Send one transaction: idle for a random gap, raise start, hold until busy is low.
    task automatic send_command(input cmd_t c);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        // Accepted at this edge: advance the mirror and queue its response.
        pending_responses = {pending_responses, apply_command(c)};
    endtask

    // Drop start and hold off until every queued response has come back.
    task automatic drain_responses();
        @(negedge clk);
        start <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    // Compare each strobed result with the oldest queued response.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("result with no transaction waiting: %p", result);
                error_count++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    error_count++;
                end
                if (result.disk_block !== want.disk_block)
                begin
                    $error("disk_block: expected %0d, got %0d",
                           want.disk_block, result.disk_block);
                    error_count++;
                end
                if (result.entry_index !== want.entry_index)
                begin
                    $error("entry_index: expected %0d, got %0d",
                           want.entry_index, result.entry_index);
                    error_count++;
                end
                if (result.file_blocks !== want.file_blocks)
                begin
                    $error("file_blocks: expected %0d, got %0d",
                           want.file_blocks, result.file_blocks);
                    error_count++;
                end
            end
        end
    end

    // Empty table right after reset: nothing to find, oversize requests rejected.
    task automatic test_empty_table();
        send_command(make_cmd(OP_MAP, '0, 0, 0));
        send_command(make_cmd(OP_DELETE, '1, 15, 7));
        send_command(make_cmd(OP_UNKNOWN, {$urandom, $urandom}, 15, 7));
        send_command(make_cmd(OP_CREATE, name_pool[2], MAX_FILE_BLOCKS + 1, 0));
        send_command(make_cmd(OP_CREATE, '1, 15, 7));
    endtask

    // Create at the size extremes and map both ends of a file.
    task automatic test_create_sizes();
        send_command(make_cmd(OP_CREATE, '1, 0, 7));
        send_command(make_cmd(OP_CREATE, '0, MAX_FILE_BLOCKS, 0));
        send_command(make_cmd(OP_CREATE, name_pool[2], 1, 3));
        send_command(make_cmd(OP_MAP, '0, 0, 7));
        send_command(make_cmd(OP_MAP, '0, 0, 0));
        send_command(make_cmd(OP_MAP, '1, 0, 0));
        send_command(make_cmd(OP_MAP, name_pool[2], 8, 1));
    endtask

    // Duplicate names: last entry wins on map, delete frees all of them.
    task automatic test_duplicate_names();
        send_command(make_cmd(OP_CREATE, name_pool[2], 3, 0));
        send_command(make_cmd(OP_MAP, name_pool[2], 0, 2));
        send_command(make_cmd(OP_MAP, name_pool[2], 0, 0));
        send_command(make_cmd(OP_DELETE, name_pool[2], 0, 0));
        send_command(make_cmd(OP_MAP, name_pool[2], 0, 0));
        send_command(make_cmd(OP_DELETE, '1, 0, 0));
        send_command(make_cmd(OP_DELETE, '0, 0, 0));
        send_command(make_cmd(OP_CREATE, name_pool[3], MAX_FILE_BLOCKS, 5));
    endtask

    // Fill every entry with full-size files, then hit no space and no free entry.
    task automatic test_table_full();
        logic [NAME_W-1:0] nm;
        int                sz;
        drain_responses();
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (slot_live[i])
                send_command(make_cmd(OP_DELETE, slot_name[i], $urandom_range(0, 15),
                                      $urandom_range(0, 7)));
        end
        for (int i = 0; i < NUM_ENTRIES; i++)
            send_command(make_cmd(OP_CREATE, pick_name(), MAX_FILE_BLOCKS,
                                  $urandom_range(0, 7)));
        send_command(make_cmd(OP_CREATE, pick_name(), $urandom_range(1, MAX_FILE_BLOCKS), 0));
        send_command(make_cmd(OP_CREATE, pick_name(), 0, 0));
        for (int i = 0; i < 12; i++)
        begin
            choose_target(nm, sz);
            if ($urandom_range(0, 1) == 0)
                send_command(make_cmd(OP_DELETE, nm, 0, 0));
            else
                send_command(make_cmd(OP_CREATE, pick_name(), $urandom_range(0, 8),
                                      $urandom_range(0, 7)));
        end
    endtask

    // Random traffic in phases that lean toward filling or emptying the table.
    task automatic test_random_traffic();
        logic [NAME_W-1:0] nm;
        int                sz;
        int                sent;
        int                create_share;
        int                roll;
        int                idx;
        sent = 0;
        for (int phase = 0; sent < RANDOM_ITEMS; phase++)
        begin
            create_share = (phase % 2 == 0) ? 70 : 25;
            gaps_on = ($urandom_range(0, 3) != 0);
            // Refresh one pool slot each phase; keep the all-zero and all-one names.
            name_pool[$urandom_range(2, POOL_SIZE - 1)] = {$urandom, $urandom};
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < create_share)
                begin
                    send_command(make_cmd(OP_CREATE, pick_name(),
                                          ($urandom_range(0, 6) == 0) ?
                                          $urandom_range(9, 15) : $urandom_range(0, 8),
                                          $urandom_range(0, 7)));
                end
                else if (roll < create_share + (97 - create_share) / 2)
                begin
                    choose_target(nm, sz);
                    send_command(make_cmd(OP_DELETE, nm, $urandom_range(0, 15),
                                          $urandom_range(0, 7)));
                end
                else if (roll < 97)
                begin
                    choose_target(nm, sz);
                    idx = (sz > 0 && $urandom_range(0, 4) != 0) ?
                          $urandom_range(0, sz - 1) : $urandom_range(0, 7);
                    send_command(make_cmd(OP_MAP, nm, $urandom_range(0, 15), idx));
                end
                else
                begin
                    send_command(make_cmd(OP_UNKNOWN, {$urandom, $urandom},
                                          $urandom_range(0, 15), $urandom_range(0, 7)));
                end
                sent++;
            end
            if ($urandom_range(0, 1) == 0)
                drain_responses();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        for (int i = 0; i < NUM_BLOCKS; i++)
            blocks_taken[i] = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            slot_live[i] = 1'b0;
            slot_name[i] = '0;
            slot_size[i] = '0;
            for (int j = 0; j < MAX_FILE_BLOCKS; j++)
                slot_map[i][j] = '0;
        end
        name_pool[0] = '0;
        name_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            name_pool[i] = {$urandom, $urandom};

        // Hold reset, then release it away from the sampling edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_create_sizes();
        test_duplicate_names();
        test_table_full();
        test_random_traffic();

        // Wait for the last response, then watch for strays before the verdict.
        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Stop a hung run; this is several times the slowest legal run.
    initial
    begin
        #20000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== file_block_allocation_table.f =====
rtl/fbat_pkg.sv
rtl/fbat_ptr_ram.sv
rtl/fbat_entry_table.sv
rtl/file_block_allocation_table.sv
tb/file_block_allocation_table_tb.sv
